// ===== rtl/rc_packet_filter_and_unpacker_unit_macros.svh =====
// Assertion macros for the remote-control packet filter and unpacker
`ifndef RC_PACKET_FILTER_AND_UNPACKER_UNIT_MACROS_SVH
`define RC_PACKET_FILTER_AND_UNPACKER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define RCPF_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define RCPF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcpf_pkg.sv =====
// Types and constants shared by the packet filter and unpacker modules
package rcpf_pkg;

  localparam int PACKET_LENGTH = 25;
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LENGTH - 1);
  localparam logic [POS_W-1:0] ADDR_BYTES = 5'd3;
  localparam logic [POS_W-1:0] STICK_FIRST = 5'd3;
  localparam logic [POS_W-1:0] STICK_LAST = 5'd18;
  localparam logic [POS_W-1:0] BUTTON_FIRST = 5'd19;
  localparam logic [POS_W-1:0] BUTTON_LAST = 5'd22;
  localparam logic [7:0] BCAST_BYTE = 8'hFF;
  localparam logic [7:0] ACK_BASE = 8'h2D;

  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] CFG_IDX_OWN_TAIL = 1'b0;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_LENGTH,
    ERR_ADDRESS,
    ERR_CHECKSUM,
    ERR_UNPAIRED
  } rcpf_err_t;

  typedef struct packed {
    rcpf_err_t        err;
    logic [47:0]      sender;
    logic [3:0][31:0] stick;
    logic [3:0][7:0]  button;
  } rcpf_pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rcpf_qstat_t;

endpackage

// ===== rtl/rcpf_if.sv =====
// Handshake channel interfaces for packet bytes and decoded results
interface rcpf_in_if;
  import rcpf_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [47:0] sender_address;

  modport source (output valid, data_byte, last_byte, sender_address, input ready);
  modport sink (input valid, data_byte, last_byte, sender_address, output ready);
endinterface

interface rcpf_out_if;
  import rcpf_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  error_code;
  logic [31:0] rudder_word;
  logic [31:0] throttle_word;
  logic [31:0] aileron_word;
  logic [31:0] elevator_word;
  logic [7:0]  arm_button;
  logic [7:0]  flip_button;
  logic [7:0]  control_mode;
  logic [7:0]  altitude_mode;
  logic [7:0]  ack_checksum;
  logic        newly_paired;

  modport source (
    output valid, error_code, rudder_word, throttle_word, aileron_word, elevator_word,
    output arm_button, flip_button, control_mode, altitude_mode, ack_checksum,
    output newly_paired,
    input  ready
  );
  modport sink (
    input  valid, error_code, rudder_word, throttle_word, aileron_word, elevator_word,
    input  arm_button, flip_button, control_mode, altitude_mode, ack_checksum,
    input  newly_paired,
    output ready
  );
endinterface

// ===== rtl/rcpf_front.sv =====
// Byte front end: position tracking, address and checksum checks, payload capture
module rcpf_front
  import rcpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [23:0]   own_tail,
  rcpf_in_if.sink       in_ch,
  input  rcpf_qstat_t   q_stat,
  output logic          push,
  output rcpf_pkt_t     push_pkt
);

  logic [POS_W-1:0]  byte_count_r;
  logic [7:0]        sum_r;
  logic              own_match_r;
  logic              bcast_match_r;
  logic              sum_ok_r;
  logic [15:0][7:0]  stick_r;
  logic [3:0][7:0]   button_r;

  logic              acc;
  logic [POS_W-1:0]  pos;
  logic [7:0]        b;
  logic [7:0]        want;
  logic              own_nxt;
  logic              bcast_nxt;
  logic [7:0]        sum_nxt;
  logic              sum_ok_nxt;
  logic [POS_W-1:0]  count_nxt;
  logic [3:0]        stick_idx;
  logic [1:0]        button_idx;
  rcpf_err_t         err;

  assign in_ch.ready = !q_stat.full;
  assign acc = in_ch.valid && in_ch.ready;
  assign pos = byte_count_r;
  assign b = in_ch.data_byte;

  always_comb begin
    unique case (pos)
      5'd0:    want = own_tail[23:16];
      5'd1:    want = own_tail[15:8];
      default: want = own_tail[7:0];
    endcase
  end

  assign own_nxt = own_match_r && !(pos < ADDR_BYTES && b != want);
  assign bcast_nxt = bcast_match_r && !(pos < ADDR_BYTES && b != BCAST_BYTE);
  assign sum_nxt = (pos < LAST_POS) ? sum_r + b : sum_r;
  assign sum_ok_nxt = (pos == LAST_POS) ? (sum_r == b) : sum_ok_r;
  assign count_nxt = (pos == COUNT_MAX) ? pos : pos + 5'd1;
  assign stick_idx = 4'(pos - STICK_FIRST);
  assign button_idx = 2'(pos - BUTTON_FIRST);

  always_comb begin
    priority if (pos != LAST_POS) begin
      err = ERR_LENGTH;
    end else if (!own_nxt && !bcast_nxt) begin
      err = ERR_ADDRESS;
    end else if (!sum_ok_nxt) begin
      err = ERR_CHECKSUM;
    end else begin
      err = ERR_OK;
    end
  end

  assign push = acc && in_ch.last_byte;
  assign push_pkt.err = err;
  assign push_pkt.sender = in_ch.sender_address;
  assign push_pkt.stick = stick_r;
  assign push_pkt.button = button_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      sum_r         <= '0;
      own_match_r   <= 1'b1;
      bcast_match_r <= 1'b1;
      sum_ok_r      <= 1'b0;
    end else if (acc) begin
      if (in_ch.last_byte) begin
        byte_count_r  <= '0;
        sum_r         <= '0;
        own_match_r   <= 1'b1;
        bcast_match_r <= 1'b1;
        sum_ok_r      <= 1'b0;
      end else begin
        byte_count_r  <= count_nxt;
        sum_r         <= sum_nxt;
        own_match_r   <= own_nxt;
        bcast_match_r <= bcast_nxt;
        sum_ok_r      <= sum_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pos >= STICK_FIRST && pos <= STICK_LAST) begin
      stick_r[stick_idx] <= b;
    end
    if (acc && pos >= BUTTON_FIRST && pos <= BUTTON_LAST) begin
      button_r[button_idx] <= b;
    end
  end

endmodule

// ===== rtl/rcpf_queue.sv =====
// Two-entry packet queue between the front end and the result stage
module rcpf_queue
  import rcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rcpf_pkt_t   push_pkt,
  input  logic        pop,
  output rcpf_pkt_t   pop_pkt,
  output rcpf_qstat_t q_stat
);

  rcpf_pkt_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_stat.full = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign pop_pkt = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

// ===== rtl/rcpf_back.sv =====
// Result stage: pairing check, partner latch and registered result
module rcpf_back
  import rcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rcpf_qstat_t q_stat,
  input  rcpf_pkt_t   pop_pkt,
  output logic        pop,
  rcpf_out_if.source  out_ch
);

  logic [47:0] paired_r;
  logic        out_valid_r;
  rcpf_err_t   err_r;
  logic [3:0][31:0] stick_r;
  logic [3:0][7:0]  button_r;
  logic [7:0]  ack_r;
  logic        newly_r;

  rcpf_err_t   err_nxt;
  logic        newly_nxt;
  logic        pass;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    newly_nxt = 1'b0;
    priority if (pop_pkt.err != ERR_OK) begin
      err_nxt = pop_pkt.err;
    end else if (paired_r == '0) begin
      err_nxt = ERR_OK;
      newly_nxt = 1'b1;
    end else if (paired_r != pop_pkt.sender) begin
      err_nxt = ERR_UNPAIRED;
    end else begin
      err_nxt = ERR_OK;
    end
  end

  assign pass = (err_nxt == ERR_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paired_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && newly_nxt) begin
        paired_r <= pop_pkt.sender;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      err_r    <= err_nxt;
      stick_r  <= pass ? pop_pkt.stick : '0;
      button_r <= pass ? pop_pkt.button : '0;
      ack_r    <= pass ? ACK_BASE + pop_pkt.button[0] + pop_pkt.button[1] : '0;
      newly_r  <= newly_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.error_code = err_r;
  assign out_ch.rudder_word = stick_r[0];
  assign out_ch.throttle_word = stick_r[1];
  assign out_ch.aileron_word = stick_r[2];
  assign out_ch.elevator_word = stick_r[3];
  assign out_ch.arm_button = button_r[0];
  assign out_ch.flip_button = button_r[1];
  assign out_ch.control_mode = button_r[2];
  assign out_ch.altitude_mode = button_r[3];
  assign out_ch.ack_checksum = ack_r;
  assign out_ch.newly_paired = newly_r;

endmodule

// ===== rtl/rc_packet_filter_and_unpacker_unit.sv =====
// Top level of the remote-control packet filter and unpacker
// Usage:
//   in_ch carries one packet byte per transfer, with last_byte on the final
//   byte and the sender address sampled with that byte. out_ch carries one
//   result per packet: an error code and, on success, the decoded stick
//   words, button and mode bytes, acknowledge checksum and pairing flag.
//   The APB port holds own_address_tail at byte address 0; write it only
//   while no packet is in flight.
//   Throughput: one byte per cycle, sustained; in_ch.ready drops only when
//   the two-entry packet queue between the byte front end and the result
//   stage is full.
//   Result path: a packet is written into the packet queue when its last
//   byte transfers, then popped into the registered result stage once
//   out_ch is free, and that register drives the result on out_ch.
//   Reset: rst_n clears the byte position, checks, queue, output valid,
//   own_address_tail and the paired partner (no partner paired).
//   Stall: a result holds on out_ch until taken; up to two more packets
//   finish into the queue, after which in_ch is held off.
module rc_packet_filter_and_unpacker_unit
  import rcpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rcpf_in_if.sink               in_ch,
  rcpf_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

`include "rc_packet_filter_and_unpacker_unit_macros.svh"

  logic [23:0]  own_tail_r;
  logic         cfg_wr;
  logic         push;
  logic         pop;
  rcpf_pkt_t    push_pkt;
  rcpf_pkt_t    pop_pkt;
  rcpf_qstat_t  q_stat;
  logic         last_xfer;
  logic         result_held;
  logic         err_out;
  logic         zero_payload;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2:2] == CFG_IDX_OWN_TAIL) ? {8'h00, own_tail_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_tail_r <= '0;
    end else if (cfg_wr && paddr[2:2] == CFG_IDX_OWN_TAIL) begin
      own_tail_r <= pwdata[23:0];
    end
  end

  rcpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .own_tail (own_tail_r),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_pkt (push_pkt)
  );

  rcpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .pop_pkt  (pop_pkt),
    .q_stat   (q_stat)
  );

  rcpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_pkt (pop_pkt),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  assign last_xfer = in_ch.valid && in_ch.ready && in_ch.last_byte;
  assign result_held = !q_stat.empty || out_ch.valid;
  assign err_out = out_ch.valid && out_ch.error_code != ERR_OK;
  assign zero_payload = out_ch.rudder_word == '0 && out_ch.ack_checksum == '0 &&
                        !out_ch.newly_paired;

  `RCPF_ASSERT_NEXT(a_last_queued, clk, rst_n, last_xfer, result_held, "last byte lost")
  `RCPF_ASSERT_SAME(a_err_no_payload, clk, rst_n, err_out, zero_payload, "payload on error")
  `RCPF_ASSERT_SAME(a_ready_full, clk, rst_n, !in_ch.ready, q_stat.full, "input held off early")

endmodule
